/* hw/rtl/sps_pkg.sv */
package sps_pkg;

    // Width of the two saturating tick counters
    localparam int CNT_W = 16;
    // Compare width: holds both a counter and a divider magnitude (up to 32768)
    localparam int CMP_W = (CNT_W > 17) ? CNT_W : 17;

    localparam int DIV_W  = 16;
    localparam int QUE_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DIV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_DIV  = 1'b1;

    localparam logic signed [DIV_W-1:0] SPEED_DIV_RST = 16'sd4;
    localparam logic signed [DIV_W-1:0] CORR_DIV_RST  = 16'sd1;

    typedef struct packed {
        logic [CNT_W-1:0]        speed_cnt;
        logic [CNT_W-1:0]        corr_cnt;
        logic signed [QUE_W-1:0] queue;
        logic signed [QUE_W-1:0] corr_left;
        logic [1:0]              phase;
    } sps_state_t;

    // One-cold coil pattern for each full-step phase
    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'hE;
            2'd1:    pat = 4'hD;
            2'd2:    pat = 4'hB;
            default: pat = 4'h7;
        endcase
        return pat;
    endfunction

    // Magnitude of a signed divider, zero-extended to the compare width
    function automatic logic [CMP_W-1:0] div_mag(input logic signed [DIV_W-1:0] d);
        logic [DIV_W:0] ext;
        logic [DIV_W:0] m;
        ext = {d[DIV_W-1], d};
        m   = d[DIV_W-1] ? ((DIV_W+1)'(0) - ext) : ext;
        return CMP_W'(m);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + CNT_W'(1);
    endfunction

    // Add +1 or -1 (when en) to the queue, clamping at the signed limits
    function automatic logic signed [QUE_W-1:0] queue_add(
        input logic signed [QUE_W-1:0] q,
        input logic                    en,
        input logic                    down
    );
        logic [QUE_W:0] delta;
        logic [QUE_W:0] s;
        logic [QUE_W-1:0] r;
        delta = !en ? '0 : (down ? '1 : (QUE_W+1)'(1));
        s = {q[QUE_W-1], q} + delta;
        if (s[QUE_W] != s[QUE_W-1])
            r = s[QUE_W] ? {1'b1, {(QUE_W-1){1'b0}}} : {1'b0, {(QUE_W-1){1'b1}}};
        else
            r = s[QUE_W-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/sps_if.sv */
interface sps_cmd_if;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic signed [15:0]   correction_count;

    modport source (output valid, operation, correction_count, input ready);
    modport sink   (input valid, operation, correction_count, output ready);
endinterface

interface sps_drive_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           coil_drive;
    logic [1:0]           phase_index;
    logic signed [15:0]   pending_steps;

    modport source (output valid, coil_drive, phase_index, pending_steps, input ready);
    modport sink   (input valid, coil_drive, phase_index, pending_steps, output ready);
endinterface

/* hw/rtl/sps_tick_logic.sv */
module sps_tick_logic (
    input  sps_pkg::sps_state_t                 cur,
    input  logic                                operation,
    input  logic signed [15:0]                  correction_count,
    input  logic signed [sps_pkg::DIV_W-1:0]    speed_div,
    input  logic signed [sps_pkg::DIV_W-1:0]    corr_div,
    output sps_pkg::sps_state_t                 nxt
);

    logic [sps_pkg::CNT_W-1:0]        speed_inc;
    logic [sps_pkg::CNT_W-1:0]        corr_inc;
    logic                             speed_fire;
    logic                             corr_fire;
    logic signed [sps_pkg::QUE_W-1:0] q_speed;
    logic signed [sps_pkg::QUE_W-1:0] q_corr;

    always_comb
    begin
        speed_inc = sps_pkg::sat_inc(cur.speed_cnt);
        corr_inc  = sps_pkg::sat_inc(cur.corr_cnt);

        speed_fire = (speed_div != '0) &&
                     (sps_pkg::CMP_W'(speed_inc) >= sps_pkg::div_mag(speed_div));
        corr_fire  = (cur.corr_left != '0) && (corr_div != '0) &&
                     (sps_pkg::CMP_W'(corr_inc) >= sps_pkg::div_mag(corr_div));

        q_speed = sps_pkg::queue_add(cur.queue, speed_fire, speed_div[sps_pkg::DIV_W-1]);
        q_corr  = sps_pkg::queue_add(q_speed, corr_fire, cur.corr_left[sps_pkg::QUE_W-1]);

        nxt = cur;
        if (operation == sps_pkg::OP_LOAD)
        begin
            nxt.corr_left = correction_count;
        end
        else
        begin
            nxt.speed_cnt = speed_fire ? '0 : speed_inc;
            nxt.corr_cnt  = corr_fire  ? '0 : corr_inc;
            if (corr_fire)
            begin
                // move the remaining correction one toward zero
                nxt.corr_left = cur.corr_left[sps_pkg::QUE_W-1] ?
                                cur.corr_left + 16'sd1 : cur.corr_left - 16'sd1;
            end
            // execute at most one queued step
            if (q_corr[sps_pkg::QUE_W-1])
            begin
                nxt.phase = cur.phase - 2'd1;
                nxt.queue = q_corr + 16'sd1;
            end
            else if (q_corr != '0)
            begin
                nxt.phase = cur.phase + 2'd1;
                nxt.queue = q_corr - 16'sd1;
            end
            else
            begin
                nxt.queue = q_corr;
            end
        end
    end

endmodule

/* hw/rtl/stepper_phase_sequencer.sv */
// Full-step stepper motor phase sequencer.
//
// cmd channel: one item per timer tick (operation = tick) or a load of a new
// signed correction count (operation = load). Every item yields exactly one
// item on the drive channel: the one-cold coil pattern, the phase index and
// the signed number of queued steps still waiting after that item.
//
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (0 = speed divider, 1 = correction divider). Write only while
// no item is in flight.
//
// The result of an item is registered and shows in the cycle after the item
// is accepted. Throughput is one item per cycle while the drive side takes
// each result; the tick update is a single pass of increments, compares and
// two saturating adds between the state registers and the result register.
//
// Reset clears the counters, step queue, correction count and phase, and
// loads the dividers with 4 and 1. When the drive side stalls the result
// register holds and cmd.ready drops until the result is taken.
module stepper_phase_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    sps_cmd_if.sink                              cmd,
    sps_drive_if.source                          drive,
    input  logic                                 cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sps_pkg::DIV_W-1:0]            cfg_data
);

    logic signed [sps_pkg::DIV_W-1:0] speed_div_reg;
    logic signed [sps_pkg::DIV_W-1:0] corr_div_reg;

    sps_pkg::sps_state_t state_reg;
    sps_pkg::sps_state_t state_next;

    logic                              out_valid_reg;
    logic [3:0]                        coil_reg;
    logic [1:0]                        phase_out_reg;
    logic signed [sps_pkg::QUE_W-1:0]  pending_reg;

    logic accept;

    // Take a new item whenever the result register is empty or being drained
    assign cmd.ready = !out_valid_reg || drive.ready;
    assign accept    = cmd.valid && cmd.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_div_reg <= sps_pkg::SPEED_DIV_RST;
            corr_div_reg  <= sps_pkg::CORR_DIV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sps_pkg::CFG_SPEED_DIV: speed_div_reg <= cfg_data;
                sps_pkg::CFG_CORR_DIV:  corr_div_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    sps_tick_logic u_tick (
        .cur              (state_reg),
        .operation        (cmd.operation),
        .correction_count (cmd.correction_count),
        .speed_div        (speed_div_reg),
        .corr_div         (corr_div_reg),
        .nxt              (state_next)
    );

    // Advance the sequencer state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: valid flag under reset, payload only loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coil_reg      <= sps_pkg::coil_pattern(state_next.phase);
            phase_out_reg <= state_next.phase;
            pending_reg   <= state_next.queue;
        end
    end

    assign drive.valid         = out_valid_reg;
    assign drive.coil_drive    = coil_reg;
    assign drive.phase_index   = phase_out_reg;
    assign drive.pending_steps = pending_reg;

endmodule
